>>> sv/fprs_pkg.sv
// Package for the FP register stack with integer operations.
// Types, constants and a double-precision helper function; no dependencies.
package fprs_pkg;
   localparam int StackDepth = 8;
   localparam int IdxW = $clog2(StackDepth);
   localparam int CntW = $clog2(StackDepth + 1);
   localparam logic [31:0] NarrowMask = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_MUL   = 2'd1,
      CMD_ADDP  = 2'd2,
      CMD_STORE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_ADD = 2'd1,
      OP_CVT = 2'd2
   } fop_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_WAIT,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      F_IDLE, F_UNP, F_M0, F_M1, F_M2, F_M3, F_MN, F_AAL, F_ASH, F_AADD, F_ANRM, F_RND,
      F_CVT, F_OUT
   } fst_type;

   // exact unsigned 32-bit integer to double
   function automatic logic [63:0] u32_to_dbl(input logic [31:0] v);
      logic [5:0] msb;
      logic [63:0] m;
      begin
         msb = '0;
         for (int i = 0; i < 32; i++) begin
            if (v[i]) msb = 6'(i);
         end
         m = {32'd0, v} << (6'd52 - msb);
         if (v == 32'd0) u32_to_dbl = 64'd0;
         else u32_to_dbl = {1'b0, 11'(11'd1023 + {5'd0, msb}), m[51:0]};
      end
   endfunction
endpackage

>>> sv/fprs_fpu.sv
// Shared multi-cycle double unit: multiply, add (round to nearest even), truncate to int32.
// Depends on fprs_pkg. Multiply accumulates 27x27 partial products in states F_M0 to F_M3.
module fprs_fpu (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  fprs_pkg::fop_type  op,
   input  logic [63:0]        a,
   input  logic [63:0]        b,
   output logic               done,
   output logic [63:0]        result
);
   import fprs_pkg::*;

   fst_type     st_ff, st_in;
   fop_type     op_ff;
   logic [63:0] a_ff, b_ff;
   logic        sa_ff, sb_ff, sr_ff;
   logic signed [13:0] ea_ff, eb_ff, er_ff;
   logic [52:0] ma_ff, mb_ff;
   logic [106:0] acc_ff;
   logic [7:0]  cnt_ff;
   logic        sticky_ff;
   logic        spec_ff;
   logic [63:0] spec_val_ff;
   logic [63:0] res_ff;
   logic        done_ff;

   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [10:0] a_e, b_e;
   logic [26:0] pa, pb;
   logic [53:0] pp;

   assign a_e = a_ff[62:52];
   assign b_e = b_ff[62:52];
   assign a_nan = (a_e == 11'h7FF) && (a_ff[51:0] != '0);
   assign b_nan = (b_e == 11'h7FF) && (b_ff[51:0] != '0);
   assign a_inf = (a_e == 11'h7FF) && (a_ff[51:0] == '0);
   assign b_inf = (b_e == 11'h7FF) && (b_ff[51:0] == '0);
   assign a_zero = (a_e == '0) && (a_ff[51:0] == '0);
   assign b_zero = (b_e == '0) && (b_ff[51:0] == '0);

   always_comb begin
      pa = '0;
      pb = '0;
      case (st_ff)
         F_M0: begin pa = ma_ff[26:0]; pb = mb_ff[26:0]; end
         F_M1: begin pa = {1'b0, ma_ff[52:27]}; pb = mb_ff[26:0]; end
         F_M2: begin pa = ma_ff[26:0]; pb = {1'b0, mb_ff[52:27]}; end
         F_M3: begin pa = {1'b0, ma_ff[52:27]}; pb = {1'b0, mb_ff[52:27]}; end
         default: begin pa = '0; pb = '0; end
      endcase
      pp = pa * pb;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         F_IDLE: if (start) st_in = F_UNP;
         F_UNP: begin
            case (op_ff)
               OP_MUL:  st_in = F_M0;
               OP_ADD:  st_in = F_AAL;
               default: st_in = F_CVT;
            endcase
         end
         F_M0:   st_in = F_M1;
         F_M1:   st_in = F_M2;
         F_M2:   st_in = F_M3;
         F_M3:   st_in = spec_ff ? F_OUT : F_MN;
         F_MN:   if (acc_ff[106]) st_in = F_RND;
         F_AAL:  st_in = spec_ff ? F_OUT : F_ASH;
         F_ASH:  st_in = F_AADD;
         F_AADD: st_in = F_ANRM;
         F_ANRM: st_in = (acc_ff == '0 && !sticky_ff) ? F_OUT : F_MN;
         F_RND:  st_in = F_IDLE;
         F_CVT:  st_in = F_IDLE;
         F_OUT:  st_in = F_IDLE;
         default: st_in = F_IDLE;
      endcase
   end

   assign done = done_ff;
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= (st_ff == F_RND) || (st_ff == F_CVT) || (st_ff == F_OUT);
         case (st_ff)
            F_IDLE: if (start) begin
               op_ff <= op; a_ff <= a; b_ff <= b;
            end
            F_UNP: begin : unp
               logic        sp;
               logic [63:0] spv;
               sp = 1'b0;
               spv = spec_val_ff;
               sa_ff <= a_ff[63]; sb_ff <= b_ff[63];
               ma_ff <= {(a_e != 0), a_ff[51:0]};
               mb_ff <= {(b_e != 0), b_ff[51:0]};
               ea_ff <= (a_e == 0) ? 14'sd1 : $signed({3'b0, a_e});
               eb_ff <= (b_e == 0) ? 14'sd1 : $signed({3'b0, b_e});
               acc_ff <= '0;
               sticky_ff <= 1'b0;
               case (op_ff)
                  OP_MUL: begin
                     if (a_nan) begin
                        sp = 1'b1; spv = a_ff | 64'h0008_0000_0000_0000;
                     end else if (b_nan) begin
                        sp = 1'b1; spv = b_ff | 64'h0008_0000_0000_0000;
                     end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                        sp = 1'b1; spv = 64'hFFF8_0000_0000_0000;
                     end else if (a_inf || b_inf) begin
                        sp = 1'b1; spv = {a_ff[63] ^ b_ff[63], 11'h7FF, 52'd0};
                     end else if (a_zero || b_zero) begin
                        sp = 1'b1; spv = {a_ff[63] ^ b_ff[63], 63'd0};
                     end
                  end
                  OP_ADD: begin
                     if (a_nan) begin
                        sp = 1'b1; spv = a_ff | 64'h0008_0000_0000_0000;
                     end else if (b_nan) begin
                        sp = 1'b1; spv = b_ff | 64'h0008_0000_0000_0000;
                     end else if (a_inf && b_inf && (a_ff[63] != b_ff[63])) begin
                        sp = 1'b1; spv = 64'hFFF8_0000_0000_0000;
                     end else if (a_inf) begin
                        sp = 1'b1; spv = a_ff;
                     end else if (b_inf) begin
                        sp = 1'b1; spv = b_ff;
                     end else if (a_zero && b_zero) begin
                        sp = 1'b1; spv = {a_ff[63] & b_ff[63], 63'd0};
                     end
                  end
                  default: ;
               endcase
               spec_ff <= sp;
               spec_val_ff <= spv;
            end
            F_M0: acc_ff <= {53'd0, pp};
            F_M1: acc_ff <= acc_ff + ({53'd0, pp} << 27);
            F_M2: acc_ff <= acc_ff + ({53'd0, pp} << 27);
            F_M3: begin
               acc_ff <= acc_ff + ({53'd0, pp} << 54);
               sr_ff <= sa_ff ^ sb_ff;
               // scaled so that a leading one at bit 106 carries exponent er
               er_ff <= ea_ff + eb_ff - 14'sd1023 + 14'sd2;
               cnt_ff <= '0;
            end
            F_MN: begin
               // place leading one at bit 106 - normalize one bit per cycle
               if (!acc_ff[106]) begin
                  acc_ff <= acc_ff << 1; er_ff <= er_ff - 14'sd1;
               end
            end
            F_AAL: begin
               // order so that a holds the larger magnitude
               if ({ea_ff, ma_ff} < {eb_ff, mb_ff}) begin
                  ea_ff <= eb_ff; eb_ff <= ea_ff; ma_ff <= mb_ff; mb_ff <= ma_ff;
                  sa_ff <= sb_ff; sb_ff <= sa_ff;
               end
            end
            F_ASH: begin
               // b mantissa extended with 3 guard bits, aligned by shifting
               if ((ea_ff - eb_ff) > 14'sd60) begin
                  acc_ff <= '0; sticky_ff <= (mb_ff != '0);
               end else begin
                  acc_ff <= {51'd0, mb_ff, 3'b0} >> (ea_ff - eb_ff);
                  sticky_ff <= (({51'd0, mb_ff, 3'b0} << (7'd107 - 7'(ea_ff - eb_ff)))
                                != '0) && (ea_ff != eb_ff);
               end
            end
            F_AADD: begin
               sr_ff <= sa_ff;
               if (sa_ff == sb_ff) acc_ff <= {51'd0, ma_ff, 3'b0} + acc_ff;
               else acc_ff <= {51'd0, ma_ff, 3'b0} - acc_ff - {106'd0, sticky_ff};
               // value = acc * 2^(ea - 1075 - 3)
               er_ff <= ea_ff + 14'sd50;
            end
            F_ANRM: begin
               if (acc_ff == '0 && !sticky_ff) begin
                  spec_ff <= 1'b1; spec_val_ff <= 64'd0;
               end else begin
                  acc_ff <= acc_ff << 50;
                  er_ff <= er_ff - 14'sd50 + 14'sd1;
               end
            end
            F_RND: begin : rnd
               // leading one at bit 106; exponent er biased
               logic [106:0] m;
               logic [13:0]  sh;
               logic [52:0]  q;
               logic         g, s;
               logic [53:0]  qr;
               logic [13:0]  e;
               sh = 14'd54;
               e = er_ff;
               m = acc_ff;
               if (er_ff < 14'sd1) begin
                  sh = 14'd54 + (14'sd1 - er_ff);
                  e = 14'sd0;
               end
               if (sh > 14'd106) begin
                  q = '0; g = 1'b0; s = 1'b1;
               end else begin
                  q = 53'(m >> sh);
                  g = m[7'(sh - 14'd1)];
                  s = ((m << (7'd108 - 7'(sh))) != '0) || sticky_ff;
               end
               qr = {1'b0, q} + {53'd0, g & (s | q[0])};
               if (e == 14'sd0) begin
                  res_ff <= {sr_ff, 63'(qr)};
               end else if (qr[53]) begin
                  res_ff <= (e + 14'sd1 >= 14'sd2047) ? {sr_ff, 11'h7FF, 52'd0}
                            : {sr_ff, 11'(e + 14'sd1), 52'd0};
               end else begin
                  res_ff <= (e >= 14'sd2047) ? {sr_ff, 11'h7FF, 52'd0}
                            : {sr_ff, 11'(e), qr[51:0]};
               end
            end
            F_CVT: begin : cvt
               logic [84:0] w;
               logic [31:0] t;
               w = {32'd0, (a_e != 0), a_ff[51:0]};
               if (a_nan) t = 32'h8000_0000;
               else if (a_e >= 11'd1054)
                  t = a_ff[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               else if (a_e < 11'd1023) t = '0;
               else begin
                  w = w << (a_e - 11'd1023);
                  t = a_ff[63] ? 32'(-w[83:52]) : w[83:52];
               end
               res_ff <= {32'd0, t};
            end
            F_OUT: res_ff <= spec_val_ff;
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) done_ff |-> st_ff == F_IDLE)
      else $error("fpu done while busy");
   assert property (@(posedge clock) disable iff (reset)
                    (st_ff == F_IDLE && start) |=> st_ff == F_UNP)
      else $error("fpu start lost");
   assert property (@(posedge clock) disable iff (reset)
                    (st_ff == F_RND || st_ff == F_CVT || st_ff == F_OUT) |=> done_ff)
      else $error("fpu done missing");
endmodule

>>> sv/fpu_register_stack_int_ops_core.sv
// FP register stack with integer load, multiply, add-pop and store-pop commands.
// Load and out-of-range add write the stack without the FPU; store, multiply and add
// use the shared FPU, whose normalize is one bit per cycle.
// One item at a time; req_stall is high while busy or while a result waits.
// Synchronous reset clears the stack to +0.0 and the count to 0.
// Depends on fprs_pkg and fprs_fpu.
module fpu_register_stack_int_ops_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_int_operand,
   input  logic        req_wide_form,
   input  logic [2:0]  req_dest_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_store_value,
   output logic        rsp_store_valid,
   output logic [3:0]  rsp_stack_count
);
   import fprs_pkg::*;

   state_type   state_ff, state_in;
   logic [63:0] stk_ff [StackDepth];
   logic [CntW-1:0] cnt_ff;
   cmd_type     cmd_ff;
   logic [31:0] opnd_ff;
   logic        wide_ff;
   logic [2:0]  dest_ff;
   logic        rv_ff;
   logic [31:0] sv_ff;
   logic        svld_ff;
   logic [3:0]  rc_ff;
   logic [63:0] opa_ff, opb_ff;

   logic        f_start, f_done;
   fop_type     f_op;
   logic [63:0] f_res;
   logic        accept;
   logic        dest_ok;
   logic [IdxW-1:0] didx;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign dest_ok = (dest_ff >= 3'd1) && ({1'b0, dest_ff} <= 4'(StackDepth));
   assign didx = IdxW'(dest_ff - 3'd1);

   fprs_fpu u_fpu (
      .clock(clock), .reset(reset), .start(f_start), .op(f_op),
      .a(opa_ff), .b(opb_ff), .done(f_done), .result(f_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_READ;
         ST_READ:  state_in = (cmd_ff == CMD_LOAD || (cmd_ff == CMD_ADDP && !dest_ok))
                              ? ST_WRITE : ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT:  if (f_done) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      f_start = (state_ff == ST_START);
      case (cmd_ff)
         CMD_MUL:  f_op = OP_MUL;
         CMD_ADDP: f_op = OP_ADD;
         default:  f_op = OP_CVT;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_store_value = sv_ff;
   assign rsp_store_valid = svld_ff;
   assign rsp_stack_count = rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         for (int i = 0; i < StackDepth; i++) stk_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (accept) begin
            cmd_ff <= cmd_type'(req_command);
            opnd_ff <= req_wide_form ? req_int_operand : (req_int_operand & NarrowMask);
            wide_ff <= req_wide_form;
            dest_ff <= req_dest_index;
         end
         if (state_ff == ST_READ) begin
            opa_ff <= stk_ff[0];
            opb_ff <= (cmd_ff == CMD_ADDP) ? stk_ff[didx] : u32_to_dbl(opnd_ff);
         end
         if (state_ff == ST_WRITE) begin
            svld_ff <= (cmd_ff == CMD_STORE);
            sv_ff <= (cmd_ff != CMD_STORE) ? '0
                     : (wide_ff ? f_res[31:0] : (f_res[31:0] & NarrowMask));
            case (cmd_ff)
               CMD_LOAD: begin
                  for (int i = StackDepth - 1; i > 0; i--) stk_ff[i] <= stk_ff[i-1];
                  stk_ff[0] <= u32_to_dbl(opnd_ff);
                  if (cnt_ff < CntW'(StackDepth)) cnt_ff <= cnt_ff + 1'b1;
               end
               CMD_MUL: stk_ff[0] <= f_res;
               default: begin : popb
                  logic [63:0] tmp [StackDepth];
                  for (int i = 0; i < StackDepth; i++) tmp[i] = stk_ff[i];
                  if (cmd_ff == CMD_ADDP && dest_ok) tmp[didx] = f_res;
                  if (cnt_ff <= CntW'(1)) cnt_ff <= '0;
                  else begin
                     for (int i = 0; i < StackDepth - 1; i++)
                        if (CntW'(i + 1) < cnt_ff) tmp[i] = tmp[i+1];
                     cnt_ff <= cnt_ff - 1'b1;
                  end
                  for (int i = 0; i < StackDepth; i++) stk_ff[i] <= tmp[i];
               end
            endcase
         end
         if (state_ff == ST_DONE) begin
            rv_ff <= 1'b1;
            rc_ff <= 4'(cnt_ff);
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) accept |=> state_ff == ST_READ)
      else $error("accept did not start");
   assert property (@(posedge clock) disable iff (reset) rv_ff |-> state_ff == ST_IDLE)
      else $error("result while busy");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= CntW'(StackDepth))
      else $error("count overflow");
   assert property (@(posedge clock) disable iff (reset) state_ff == ST_DONE |=> rv_ff)
      else $error("result missing");
endmodule

>>> tb/tb_fpu_register_stack_int_ops_core.sv
// Testbench for fpu_register_stack_int_ops_core: random bursty commands, random result stalls,
// and a double-precision stack predictor kept in a small scoreboard class.
// Depends on fprs_pkg and the block's RTL.
module tb_fpu_register_stack_int_ops_core;
   timeunit 1ns;
   timeprecision 1ps;
   import fprs_pkg::*;

   typedef struct packed {
      logic [31:0] store_value;
      logic        store_valid;
      logic [3:0]  stack_count;
   } stack_result_type;

   class fpu_stack_scoreboard;
      real              entries[StackDepth];
      int unsigned      occupied;
      stack_result_type pending[$];
      int               errors;
      int               checked;
      int               stores;
      int               nan_stores;
      int               sat_stores;

      function new();
         foreach (entries[i]) entries[i] = 0.0;
         occupied = 0;
         errors = 0;
         checked = 0;
         stores = 0;
         nan_stores = 0;
         sat_stores = 0;
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
      endfunction

      function void drop_top();
         if (occupied <= 1) begin
            occupied = 0;
            return;
         end
         for (int i = 0; i + 1 < occupied && i + 1 < StackDepth; i++)
            entries[i] = entries[i + 1];
         occupied--;
      endfunction

      function logic [31:0] trunc_sat(real d);
         if (d != d) begin
            nan_stores++;
            return 32'h8000_0000;
         end
         if (d >= 2147483648.0) begin
            sat_stores++;
            return 32'h7FFF_FFFF;
         end
         if (d <= -2147483649.0) begin
            sat_stores++;
            return 32'h8000_0000;
         end
         return 32'($rtoi(d));
      endfunction

      function void note_command(cmd_type c, logic [31:0] opnd, logic wide, logic [2:0] dest);
         stack_result_type r;
         real v;
         r = '0;
         if (!wide) opnd = opnd & NarrowMask;
         v = real'(longint'({32'd0, opnd}));
         case (c)
            CMD_LOAD: begin
               for (int i = StackDepth - 1; i > 0; i--) entries[i] = entries[i - 1];
               entries[0] = v;
               if (occupied < StackDepth) occupied++;
            end
            CMD_MUL: entries[0] = entries[0] * v;
            CMD_ADDP: begin
               if (dest >= 1 && dest <= StackDepth)
                  entries[dest - 1] = entries[dest - 1] + entries[0];
               drop_top();
            end
            default: begin
               r.store_value = trunc_sat(entries[0]);
               if (!wide) r.store_value = r.store_value & NarrowMask;
               r.store_valid = 1'b1;
               stores++;
               drop_top();
            end
         endcase
         r.stack_count = 4'(occupied);
         pending.push_back(r);
      endfunction

      function void check_result(logic [31:0] sval, logic svalid, logic [3:0] cnt);
         stack_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("MISMATCH unexpected result: value %h valid %b count %0d", sval, svalid, cnt);
            return;
         end
         e = pending.pop_front();
         if (sval !== e.store_value) report("store_value", sval, e.store_value);
         if (svalid !== e.store_valid) report("store_valid", 32'(svalid), 32'(e.store_valid));
         if (cnt !== e.stack_count) report("stack_count", 32'(cnt), 32'(e.stack_count));
         checked++;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = CMD_LOAD;
   logic [31:0] req_int_operand = '0;
   logic        req_wide_form = 1'b0;
   logic [2:0]  req_dest_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic signed [31:0] rsp_store_value;
   logic        rsp_store_valid;
   logic [3:0]  rsp_stack_count;

   fpu_stack_scoreboard sb = new();
   int  sent = 0;
   int  burst_left = 0;
   bit  held_off = 1'b0;
   bit  stimulus_done = 1'b0;
   longint cycles = 0;

   fpu_register_stack_int_ops_core uut (.*);

   initial forever #1 clock = ~clock;

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 1_000_000) begin
         $display("timeout with %0d results outstanding", sb.pending.size());
         $display("fpu_register_stack_int_ops_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_store_value, rsp_store_valid, rsp_stack_count);
         if (req_valid && !req_stall)
            sb.note_command(cmd_type'(req_command), req_int_operand, req_wide_form,
                            req_dest_index);
      end
   end

   // result side: calm runs, random stalls, and one long hold-off
   initial begin
      int n;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!held_off && sent >= 300) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         n = $urandom_range(1, 30);
         case ($urandom_range(0, 2))
            0: begin
               rsp_stall <= 1'b0;
               repeat (n) @(posedge clock);
            end
            1: repeat (n) begin
               rsp_stall <= ($urandom_range(0, 1) == 1);
               @(posedge clock);
            end
            default: repeat (n) begin
               rsp_stall <= ($urandom_range(0, 7) != 0);
               @(posedge clock);
            end
         endcase
      end
   end

   task automatic offer(cmd_type c, logic [31:0] opnd, logic wide, logic [2:0] dest);
      int gap;
      req_valid <= 1'b1;
      req_command <= c;
      req_int_operand <= opnd;
      req_wide_form <= wide;
      req_dest_index <= dest;
      do @(posedge clock); while (req_stall);
      sent++;
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [31:0] pick_operand(bit mostly_small);
      case ($urandom_range(0, 9))
         0: return 32'hFFFF_FFFF;
         1: return 32'(0);
         2: return $urandom_range(0, 3);
         3, 4: return $urandom_range(0, 20);
         default: return mostly_small ? $urandom_range(0, 4) : $urandom();
      endcase
   endfunction

   initial begin
      int sel;
      cmd_type c;
      @(negedge reset);
      @(posedge clock);
      // directed: empty stack, extremes, overflow to infinity and NaN, deep pushes
      offer(CMD_STORE, 32'h0, 1'b1, 3'd1);
      offer(CMD_ADDP, 32'h0, 1'b1, 3'd1);
      offer(CMD_MUL, 32'hFFFF_FFFF, 1'b1, 3'd0);
      offer(CMD_LOAD, 32'hFFFF_FFFF, 1'b1, 3'd7);
      offer(CMD_LOAD, 32'hABCD_8001, 1'b0, 3'd0);
      offer(CMD_STORE, 32'h0, 1'b0, 3'd0);
      offer(CMD_STORE, 32'h0, 1'b1, 3'd0);
      offer(CMD_LOAD, 32'h7FFF_FFFF, 1'b1, 3'd0);
      offer(CMD_STORE, 32'h0, 1'b1, 3'd0);
      for (int i = 0; i < 9; i++) offer(CMD_LOAD, 32'(i * 1000 + 1), 1'b1, 3'(i));
      offer(CMD_ADDP, 32'h0, 1'b1, 3'd7);
      offer(CMD_ADDP, 32'h0, 1'b1, 3'd0);
      offer(CMD_LOAD, 32'hFFFF_FFFF, 1'b1, 3'd0);
      repeat (35) offer(CMD_MUL, 32'hFFFF_FFFF, 1'b1, 3'd0);
      offer(CMD_MUL, 32'hFFFF_FFFF, 1'b1, 3'd0);
      offer(CMD_MUL, 32'h0, 1'b1, 3'd0);
      offer(CMD_STORE, 32'h0, 1'b0, 3'd0);
      repeat (1250) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) c = CMD_LOAD;
         else if (sel < 55) c = CMD_MUL;
         else if (sel < 75) c = CMD_ADDP;
         else c = CMD_STORE;
         offer(c, pick_operand(c == CMD_MUL), 1'($urandom_range(0, 1)),
               3'($urandom_range(0, 7)));
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("%0d commands sent, %0d results checked, %0d stores (%0d saturated, %0d NaN)",
               sent, sb.checked, sb.stores, sb.sat_stores, sb.nan_stores);
      $display("one long result hold-off applied: %0d", held_off);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("fpu_register_stack_int_ops_core verification clean");
      else
         $display("fpu_register_stack_int_ops_core verification failed");
      $finish;
   end
endmodule
